[rtl/core/oas_pkg.sv]
`default_nettype none
package oas_pkg;

    // fixed field widths
    localparam int DIST_W      = 16;
    localparam int FILT_W      = DIST_W + 8;
    localparam int TIME_W      = 32;
    localparam int ANGLE_W     = 20;
    localparam int ANGLE_FRAC  = 16;
    localparam int CODE_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 24;

    // divider geometry
    localparam int DIV_NUM_W   = 42;
    localparam int DIV_DEN_W   = 24;
    localparam int DIV_Q_W     = 18;
    localparam int DIV_CNT_W   = 5;

    // arithmetic constants
    localparam int ONE_Q16        = 65536;
    localparam int DT_MAX_MS      = 200;
    localparam int ALPHA_MIN      = 655;
    localparam int RATE_MIN       = 3277;
    localparam int MS_PER_S       = 1000;
    localparam int ANGLE_ONE      = 1 << ANGLE_FRAC;
    localparam int ANGLE_HARD_MAX = (65 * ANGLE_ONE) / 100;
    localparam int SNAP_LIMIT     = (ANGLE_ONE + 9999) / 10000;
    localparam int ZERO_TURN_MAX  = ANGLE_ONE / 1000000;

    // reciprocal of one second in ms, exact floor for products below 2^27
    localparam int          MS_RECIP_SHIFT = 37;
    localparam logic [27:0] MS_RECIP       =
        28'(((64'd1 << MS_RECIP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));

    // register reset values
    localparam logic [15:0] SAFE_RST    = 16'd1700;
    localparam logic [15:0] ESTOP_RST   = 16'd600;
    localparam logic [15:0] FULL_RST    = 16'd900;
    localparam logic [16:0] ALPHA_RST   = 17'd16384;
    localparam logic [19:0] RATE_RST    = 20'd78643;
    localparam logic [15:0] DBAND_RST   = 16'd250;
    localparam logic [15:0] AMAX_RST    = 16'd19661;
    localparam logic [15:0] TMO_RST     = 16'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAFE  = 3'd0,
        REG_ESTOP = 3'd1,
        REG_FULL  = 3'd2,
        REG_ALPHA = 3'd3,
        REG_RATE  = 3'd4,
        REG_DBAND = 3'd5,
        REG_AMAX  = 3'd6,
        REG_TMO   = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_FRONT = 2'd0,
        OP_LEFT  = 2'd1,
        OP_RIGHT = 2'd2,
        OP_TICK  = 2'd3
    } opcode_t;

    typedef enum logic [CODE_W-1:0] {
        DRV_CRUISE  = 3'd0,
        DRV_TURNING = 3'd1,
        DRV_NO_DATA = 3'd2,
        DRV_STALE   = 3'd3,
        DRV_ESTOP   = 3'd4,
        DRV_ZERO    = 3'd5
    } drive_code_t;

    typedef enum logic [1:0] {
        SIDE_NONE  = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } side_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FMUL,
        ST_FWR,
        ST_TCHK,
        ST_UDIV,
        ST_UTAKE,
        ST_SQ,
        ST_SM,
        ST_MAG,
        ST_SIDE,
        ST_RMUL,
        ST_RSCALE,
        ST_RUPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic filt_mul;
        logic filt_wr;
        logic tick_chk;
        logic div_step;
        logic u_take;
        logic sq_mul;
        logic sm_mul;
        logic mag_mul;
        logic side_upd;
        logic rate_mul;
        logic rate_scale;
        logic tick_upd;
        logic out_wr;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic need_div;
        logic div_last;
        logic started;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

[rtl/core/oas_div.sv]
`default_nettype none
module oas_div
    import oas_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire logic                 step,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic      [DIV_Q_W-1:0]   quot,
    output logic                      sat,
    output logic                      last
);

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic                 sat_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_NUM_W:0]   den_top;
    logic                 fits;

    // quotient overflow check on load
    assign den_top = {{(DIV_NUM_W+1-DIV_DEN_W){1'b0}}, den} << DIV_Q_W;
    assign fits    = rem_reg >= den_reg;

    // restoring division, one quotient bit per cycle while step is asserted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sat_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_Q_W - 1);
            sat_reg <= {1'b0, num} >= den_top;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= num;
            den_reg <= {{(DIV_NUM_W-DIV_DEN_W){1'b0}}, den} << (DIV_Q_W - 1);
            q_reg   <= '0;
        end
        else if (step)
        begin
            if (fits)
                rem_reg <= rem_reg - den_reg;
            q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign quot = q_reg;
    assign sat  = sat_reg;
    assign last = cnt_reg == '0;

endmodule
`default_nettype wire

[rtl/core/oas_dp.sv]
`default_nettype none
module oas_dp
    import oas_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic [1:0]            in_op,
    input  wire logic                  cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_val,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data
);

    // configuration registers
    logic [15:0] safe_reg, estop_reg, full_reg, dband_reg, amax_reg, tmo_reg;
    logic [16:0] alpha_reg;
    logic [19:0] rate_reg;

    // captured item
    logic [1:0]        op_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [TIME_W-1:0] time_reg;

    // channel state
    logic [FILT_W-1:0] filt_reg [3];
    logic [TIME_W-1:0] stime_reg [3];
    logic [2:0]        seen_reg;
    logic [DIST_W-1:0] raw_front_reg;
    side_t             side_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic              started_reg;
    logic [TIME_W-1:0] last_tick_reg;

    // tick working registers
    logic              clear_reg;
    logic [16:0]       u_reg;
    logic [15:0]       mag_reg;
    logic              zero_reg;
    logic [17:0]       maxc_reg;
    logic signed [46:0] prod_reg;

    // output register
    logic                  ovalid_reg;
    logic [OUT_DATA_W-1:0] odata_reg;
    logic [ANGLE_W-1:0]    res_angle_reg;
    drive_code_t           res_code_reg;

    logic [FILT_W-1:0]  target;
    logic signed [24:0] fdiff;
    logic [16:0]        alpha_c;
    logic [19:0]        rate_c;
    logic signed [25:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [46:0] rnd;
    logic [16:0]        prod_hi;
    logic [54:0]        scale_prod;
    logic [24:0]        safe_sh;
    logic signed [16:0] span;
    logic               clear_c;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_load;
    logic [DIV_Q_W-1:0] quot;
    logic               sat;
    logic               div_last;
    logic [17:0]        sm_fac;
    logic [16:0]        mag_raw;
    logic signed [24:0] side_diff;
    logic signed [24:0] db_s;
    logic [TIME_W-1:0]  dt32;
    logic [7:0]         dt;
    logic signed [ANGLE_W:0] tgt;
    logic signed [ANGLE_W:0] req;
    logic signed [ANGLE_W:0] maxc;
    logic signed [ANGLE_W:0] req_c;
    logic signed [ANGLE_W-1:0] new_angle;
    logic [2:0]         fresh;
    drive_code_t        code_c;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_reg  <= SAFE_RST;
            estop_reg <= ESTOP_RST;
            full_reg  <= FULL_RST;
            alpha_reg <= ALPHA_RST;
            rate_reg  <= RATE_RST;
            dband_reg <= DBAND_RST;
            amax_reg  <= AMAX_RST;
            tmo_reg   <= TMO_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_idx))
                REG_SAFE:  safe_reg  <= cfg_val[15:0];
                REG_ESTOP: estop_reg <= cfg_val[15:0];
                REG_FULL:  full_reg  <= cfg_val[15:0];
                REG_ALPHA: alpha_reg <= cfg_val[16:0];
                REG_RATE:  rate_reg  <= cfg_val;
                REG_DBAND: dband_reg <= cfg_val[15:0];
                REG_AMAX:  amax_reg  <= cfg_val[15:0];
                REG_TMO:   tmo_reg   <= cfg_val[15:0];
                default:   ;
            endcase
        end
    end

    // clamped weights
    always_comb
    begin
        if (alpha_reg < 17'(ALPHA_MIN))
            alpha_c = 17'(ALPHA_MIN);
        else if (alpha_reg > 17'(ONE_Q16))
            alpha_c = 17'(ONE_Q16);
        else
            alpha_c = alpha_reg;
        rate_c = (rate_reg < 20'(RATE_MIN)) ? 20'(RATE_MIN) : rate_reg;
    end

    // filter error and tick time step
    assign target = {dist_reg, 8'd0};
    assign fdiff  = $signed({1'b0, target}) - $signed({1'b0, filt_reg[op_reg]});
    assign dt32   = time_reg - last_tick_reg;
    always_comb
    begin
        if (dt32[TIME_W-1])
            dt = 8'd0;
        else if (dt32 > TIME_W'(DT_MAX_MS))
            dt = 8'(DT_MAX_MS);
        else
            dt = dt32[7:0];
    end

    // previous product in q16, feeds the smoothstep and magnitude steps
    assign prod_hi = prod_reg[32:16];

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        sm_fac = 18'(3 * ONE_Q16) - {u_reg, 1'b0};
        if (cmd.filt_mul)
        begin
            mul_a = 26'(fdiff);
            mul_b = $signed({4'd0, alpha_c});
        end
        else if (cmd.sq_mul)
        begin
            mul_a = $signed({9'd0, u_reg});
            mul_b = $signed({4'd0, u_reg});
        end
        else if (cmd.sm_mul)
        begin
            mul_a = $signed({9'd0, prod_hi});
            mul_b = $signed({3'd0, sm_fac});
        end
        else if (cmd.mag_mul)
        begin
            mul_a = $signed({10'd0, amax_reg});
            mul_b = $signed({4'd0, prod_hi});
        end
        else if (cmd.rate_mul)
        begin
            mul_a = $signed({18'd0, dt});
            mul_b = $signed({1'b0, rate_c});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.filt_mul || cmd.sq_mul || cmd.sm_mul || cmd.mag_mul || cmd.rate_mul)
            prod_reg <= 47'(mul_a * mul_b);
    end

    // urgency setup
    assign safe_sh  = {1'b0, safe_reg, 8'd0};
    assign clear_c  = {1'b0, filt_reg[0]} >= safe_sh;
    assign span     = $signed({1'b0, safe_reg}) - $signed({1'b0, full_reg});
    assign div_load = cmd.tick_chk && stat.need_div;
    assign div_num  = DIV_NUM_W'({(safe_sh - {1'b0, filt_reg[0]}), 16'd0});
    assign div_den  = {span[15:0], 8'd0};

    oas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (div_load),
        .step  (cmd.div_step),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .sat   (sat),
        .last  (div_last)
    );

    // per-tick change limit: rate times ms over one second by reciprocal
    assign scale_prod = prod_reg[26:0] * MS_RECIP;

    assign rnd       = prod_reg + 47'sd32768;
    assign mag_raw   = prod_reg[32:16];
    assign side_diff = $signed({1'b0, filt_reg[1]}) - $signed({1'b0, filt_reg[2]});
    assign db_s      = $signed({1'b0, dband_reg, 8'd0});

    // rate limiter step
    always_comb
    begin
        case (side_reg)
            SIDE_LEFT:  tgt = $signed({5'd0, mag_reg});
            SIDE_RIGHT: tgt = -$signed({5'd0, mag_reg});
            default:    tgt = '0;
        endcase
        maxc = $signed({3'd0, maxc_reg});
        req  = tgt - 21'(angle_reg);
        if (req > maxc)
            req_c = maxc;
        else if (req < -maxc)
            req_c = -maxc;
        else
            req_c = req;
        new_angle = angle_reg + req_c[ANGLE_W-1:0];
        if (new_angle > -20'sd7 && new_angle < 20'(SNAP_LIMIT))
            new_angle = '0;
    end

    // drive code
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fresh[i] = (time_reg - stime_reg[i]) >= 32'h8000_0000
                    || (time_reg - stime_reg[i]) <= {16'd0, tmo_reg};
        end
        if (seen_reg != 3'b111)
            code_c = DRV_NO_DATA;
        else if (fresh != 3'b111)
            code_c = DRV_STALE;
        else if (raw_front_reg <= estop_reg)
            code_c = DRV_ESTOP;
        else if (!clear_reg && zero_reg)
            code_c = DRV_ZERO;
        else if (!clear_reg)
            code_c = DRV_TURNING;
        else
            code_c = DRV_CRUISE;
    end

    // control state of the channels and the limiter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                filt_reg[i]  <= '0;
                stime_reg[i] <= '0;
            end
            seen_reg      <= '0;
            raw_front_reg <= '0;
            side_reg      <= SIDE_NONE;
            angle_reg     <= '0;
            started_reg   <= 1'b0;
            last_tick_reg <= '0;
        end
        else
        begin
            if (cmd.filt_wr)
            begin
                if (!seen_reg[op_reg])
                    filt_reg[op_reg] <= target;
                else
                    filt_reg[op_reg] <= filt_reg[op_reg] + rnd[39:16];
                seen_reg[op_reg]  <= 1'b1;
                stime_reg[op_reg] <= time_reg;
                if (op_reg == OP_FRONT)
                    raw_front_reg <= dist_reg;
            end
            if (cmd.side_upd && !clear_reg)
            begin
                case (side_reg)
                    SIDE_NONE:  side_reg <= (side_diff >= 0) ? SIDE_LEFT : SIDE_RIGHT;
                    SIDE_LEFT:  if (side_diff < -db_s) side_reg <= SIDE_RIGHT;
                    SIDE_RIGHT: if (side_diff > db_s) side_reg <= SIDE_LEFT;
                    default:    side_reg <= SIDE_NONE;
                endcase
            end
            if (cmd.tick_upd)
            begin
                last_tick_reg <= time_reg;
                started_reg   <= 1'b1;
                angle_reg     <= started_reg ? new_angle : '0;
            end
        end
    end

    // item capture and tick working values
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            dist_reg <= in_data[DIST_W-1:0];
            time_reg <= in_data[IN_DATA_W-1:DIST_W];
        end
        if (cmd.tick_chk)
        begin
            clear_reg <= clear_c;
            if (clear_c)
                u_reg <= '0;
            else
                u_reg <= 17'(ONE_Q16);
        end
        if (cmd.u_take)
            u_reg <= (sat || quot > 18'(ONE_Q16)) ? 17'(ONE_Q16) : quot[16:0];
        if (cmd.side_upd)
        begin
            mag_reg  <= (mag_raw > 17'(ANGLE_HARD_MAX)) ? 16'(ANGLE_HARD_MAX)
                                                        : mag_raw[15:0];
            zero_reg <= mag_raw <= 17'(ZERO_TURN_MAX);
        end
        if (cmd.rate_scale)
            maxc_reg <= scale_prod[MS_RECIP_SHIFT +: 18];
        if (cmd.tick_upd)
        begin
            res_angle_reg <= started_reg ? new_angle : '0;
            res_code_reg  <= code_c;
        end
        if (cmd.out_wr)
            odata_reg <= {side_reg == SIDE_LEFT, res_code_reg, res_angle_reg};
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.out_wr)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    assign stat.is_tick  = in_op == OP_TICK;
    assign stat.need_div = !clear_c && span > 0;
    assign stat.div_last = div_last;
    assign stat.started  = started_reg;
    assign stat.out_free = !ovalid_reg || out_ready;

    // the limiter never leaves the hard angle bound
    a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        angle_reg <= 20'sd42598 && angle_reg >= -20'sd42598)
        else $error("steering angle beyond hard limit");

    // snapped angles leave no tiny residue
    a_snap: assert property (@(posedge clk) disable iff (!rst_n)
        angle_reg == '0 || angle_reg >= 20'(SNAP_LIMIT) || angle_reg <= -20'sd7)
        else $error("unsnapped small angle");

    // urgency stays within one
    a_urgency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.u_take) |-> u_reg <= 17'(ONE_Q16))
        else $error("urgency above one");

    // a result enters only while the output register is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_wr |-> (!ovalid_reg || out_ready))
        else $error("result overwritten");

endmodule
`default_nettype wire

[rtl/core/oas_ctrl.sv]
`default_nettype none
module oas_ctrl
    import oas_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (in_valid) state_next = stat.is_tick ? ST_TCHK : ST_FMUL;
            ST_FMUL:    state_next = ST_FWR;
            ST_FWR:     state_next = ST_IDLE;
            ST_TCHK:    state_next = stat.need_div ? ST_UDIV : ST_SQ;
            ST_UDIV:    if (stat.div_last) state_next = ST_UTAKE;
            ST_UTAKE:   state_next = ST_SQ;
            ST_SQ:      state_next = ST_SM;
            ST_SM:      state_next = ST_MAG;
            ST_MAG:     state_next = ST_SIDE;
            ST_SIDE:    state_next = ST_RMUL;
            ST_RMUL:    state_next = stat.started ? ST_RSCALE : ST_RUPD;
            ST_RSCALE:  state_next = ST_RUPD;
            ST_RUPD:    state_next = ST_OUT;
            ST_OUT:     if (stat.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_FMUL:    cmd.filt_mul      = 1'b1;
            ST_FWR:     cmd.filt_wr       = 1'b1;
            ST_TCHK:    cmd.tick_chk      = 1'b1;
            ST_UDIV:    cmd.div_step      = 1'b1;
            ST_UTAKE:   cmd.u_take        = 1'b1;
            ST_SQ:      cmd.sq_mul        = 1'b1;
            ST_SM:      cmd.sm_mul        = 1'b1;
            ST_MAG:     cmd.mag_mul       = 1'b1;
            ST_SIDE:    cmd.side_upd      = 1'b1;
            ST_RMUL:    cmd.rate_mul      = 1'b1;
            ST_RSCALE:  cmd.rate_scale    = 1'b1;
            ST_RUPD:    cmd.tick_upd      = 1'b1;
            ST_OUT:     cmd.out_wr        = stat.out_free;
            default:    ;
        endcase
    end

    // input taken only when no item is in flight
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != ST_IDLE)
        else $error("accepted item not started");

    // divider steps only in its own state
    a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> state_reg == ST_UDIV)
        else $error("stray divider step");

    // every tick update is followed by its result hand-off
    a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick_upd |=> state_reg == ST_OUT)
        else $error("tick result lost");

endmodule
`default_nettype wire

[rtl/core/obstacle_avoid_steering.sv]
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: distance_mm, time_ms; tuser: opcode
// m_axis    out  m_axis_tvalid/tready      tdata: steer_angle, drive_code, turn_left
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// a range sample runs capture, filter multiply and write back in turn
// a tick runs capture, clear check, the 18-step urgency divide when it is needed,
// square, smoothstep, magnitude, side, rate multiply, rate scale (not on the first
// tick), angle update and output; its multiply steps share the single multiplier
// rst_n clears all channel, limiter and handshake state; registers take their defaults
// one result sits in an output register; a further tick waits in its last state,
// holding off s_axis, until m_axis takes the held result
`default_nettype none
module obstacle_avoid_steering
    import oas_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // distance_mm[15:0], time_ms[47:16]
    input  wire logic [1:0]            s_axis_tuser,   // opcode[1:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // steer_angle[19:0], drive_code[22:20],
                                                       // turn_left[23]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    oas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    oas_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
`default_nettype wire
